/* design/cqw_pkg.sv */
// Shared types, codes and sizes for the circular queue with walk.
package cqw_pkg;

    localparam int DEPTH    = 8;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;
    localparam logic [1:0] OP_WALK = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] elem;
        logic               elem_valid;
        logic               last;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
        logic [CNT_W-1:0]   count;
        logic               is_full;
        logic               is_empty;
    } t_res;

endpackage

/* design/cqw_front.sv */
// Front end: take input beats and hold them in a short command queue.
module cqw_front
    import cqw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic                push;
    logic                pop;

    assign o_stall     = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    function automatic logic [CQ_PTR_W-1:0] cq_inc(input logic [CQ_PTR_W-1:0] p);
        cq_inc = (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_op, value: i_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= cq_inc(r_wp);
            end
            if (pop) begin
                r_rp <= cq_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CQ_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CQ_CNT_W'(1);
            end
        end
    end

endmodule

/* design/cqw_back.sv */
// Back end: ring buffer state, slot memory, walk sequencer and result register.
module cqw_back
    import cqw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEQ  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0]         r_state,    n_state;
    logic [PTR_W-1:0]   r_head,     n_head;
    logic [PTR_W-1:0]   r_tail,     n_tail;
    logic [PTR_W-1:0]   r_idx,      n_idx;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [CNT_W-1:0]   r_left,     n_left;
    logic signed [31:0] r_head_val, n_head_val;
    logic signed [31:0] r_tail_val, n_tail_val;
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_mem [DEPTH];
    logic               r_out_valid;
    t_res               r_res;

    logic               out_free;
    logic               load;
    logic               wr_en;
    logic [1:0]         res_status;
    logic signed [31:0] res_elem;
    logic               res_ev;
    logic               res_last;
    logic               n_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign n_empty  = (n_count == '0);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_idx      = r_idx;
        n_count    = r_count;
        n_left     = r_left;
        n_head_val = r_head_val;
        n_tail_val = r_tail_val;
        o_cmd_pop  = 1'b0;
        load       = 1'b0;
        wr_en      = 1'b0;
        res_status = STAT_OK;
        res_elem   = '0;
        res_ev     = 1'b0;
        res_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_ENQ: begin
                            load = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                res_status = STAT_FULL;
                            end else begin
                                n_tail     = ptr_inc(r_tail);
                                wr_en      = 1'b1;
                                n_count    = r_count + CNT_W'(1);
                                n_tail_val = i_cmd.value;
                                if (r_count == '0) begin
                                    n_head_val = i_cmd.value;
                                end
                            end
                        end
                        OP_DEQ: begin
                            if (r_count == '0) begin
                                load       = 1'b1;
                                res_status = STAT_EMPTY;
                            end else begin
                                n_head  = ptr_inc(r_head);
                                n_idx   = ptr_inc(r_head);
                                n_count = r_count - CNT_W'(1);
                                n_state = S_DEQ;
                            end
                        end
                        OP_CLR: begin
                            load    = 1'b1;
                            n_head  = '0;
                            n_tail  = PTR_W'(DEPTH - 1);
                            n_idx   = '0;
                            n_count = '0;
                        end
                        default: begin
                            if (r_count == '0) begin
                                load = 1'b1;
                            end else begin
                                n_left  = r_count;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_DEQ: begin
                // read data now holds the new oldest word
                if (out_free) begin
                    load       = 1'b1;
                    n_head_val = r_rd_data;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (out_free) begin
                    load     = 1'b1;
                    res_elem = r_rd_data;
                    res_ev   = 1'b1;
                    res_last = (r_left == CNT_W'(1));
                    n_left   = r_left - CNT_W'(1);
                    if (res_last) begin
                        n_idx   = r_head;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = ptr_inc(r_idx);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory; read data tracks the slot at the index register, with write bypass.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[n_tail] <= i_cmd.value;
        end
        if (wr_en && (n_tail == n_idx)) begin
            r_rd_data <= i_cmd.value;
        end else begin
            r_rd_data <= r_mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_head_val <= n_head_val;
        r_tail_val <= n_tail_val;
        if (load) begin
            r_res.status     <= res_status;
            r_res.elem       <= res_elem;
            r_res.elem_valid <= res_ev;
            r_res.last       <= res_last;
            r_res.head_value <= n_empty ? 32'sd0 : n_head_val;
            r_res.tail_value <= n_empty ? 32'sd0 : n_tail_val;
            r_res.count      <= n_count;
            r_res.is_full    <= (n_count == CNT_W'(DEPTH));
            r_res.is_empty   <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= PTR_W'(DEPTH - 1);
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_idx == r_head))
        else $error("read index off head while idle");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0 && r_left <= r_count))
        else $error("walk count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_res)))
        else $error("result register overwritten while stalled");

endmodule

/* design/circular_queue_with_walk_core.sv */
// Top level of the circular queue with walk: front queue plus execution back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  command | in        | i_valid / o_stall  | i_op, i_value
//  result  | out       | o_valid / i_stall  | o_status, o_elem, o_elem_valid, o_last,
//          |           |                    | o_head_value, o_tail_value, o_count,
//          |           |                    | o_is_full, o_is_empty
//
// Enqueue, clear and refused ops load the result straight from the idle state; a dequeue
// also passes through a second state that waits on the registered slot read of the new oldest word.
// A walk of n words first reads the oldest word, then gives one beat a cycle while i_stall allows it.
// A two-beat command queue lets input beats keep arriving while the back end walks or
// the result register waits on i_stall.
// Reset (synchronous, active low) empties the queue; slot contents are never cleared.
module circular_queue_with_walk_core
    import cqw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_elem,
    output logic               o_elem_valid,
    output logic               o_last,
    output logic signed [31:0] o_head_value,
    output logic signed [31:0] o_tail_value,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_is_full,
    output logic               o_is_empty
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    t_res res;

    // Front: accept beats and buffer them as commands.
    cqw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: run each command against the ring and register its result beats.
    cqw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (res)
    );

    // Break the result struct out onto its ports.
    assign o_status     = res.status;
    assign o_elem       = res.elem;
    assign o_elem_valid = res.elem_valid;
    assign o_last       = res.last;
    assign o_head_value = res.head_value;
    assign o_tail_value = res.tail_value;
    assign o_count      = res.count;
    assign o_is_full    = res.is_full;
    assign o_is_empty   = res.is_empty;

endmodule
